// File: design/bresenham_line_pixel_stepper_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the line pixel stepper
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_PIXEL_STEPPER_MACROS_SVH
`define BRESENHAM_LINE_PIXEL_STEPPER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define BLS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line stepper check failed");
// next-cycle implication, disabled during reset
`define BLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line stepper check failed");
`else
`define BLS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define BLS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: design/bls_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Line pixel stepper package
// Widths, types and action codes shared by the line stepper.
// ---------------------------------------------------------------------------
package bls_pkg;

   localparam int COORD_WIDTH    = 12;
   localparam int COLOUR_WIDTH   = 16;
   // signed endpoint difference
   localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
   // doubled distance
   localparam int TWICE_WIDTH    = COORD_WIDTH + 1;
   // remaining pixel count
   localparam int COUNT_WIDTH    = COORD_WIDTH + 1;
   // signed error term, headroom for the subtract-then-add step
   localparam int DECISION_WIDTH = COORD_WIDTH + 3;

   typedef logic [COORD_WIDTH-1:0]           coord_type;
   typedef logic [COLOUR_WIDTH-1:0]          colour_type;
   typedef logic signed [DIFF_WIDTH-1:0]     diff_type;
   typedef logic [TWICE_WIDTH-1:0]           twice_type;
   typedef logic [COUNT_WIDTH-1:0]           count_type;
   typedef logic signed [DECISION_WIDTH-1:0] decision_type;

   typedef enum logic {
      ACTION_LOAD    = 1'b0,
      ACTION_ADVANCE = 1'b1
   } action_type;

endpackage

// File: design/bresenham_line_pixel_stepper.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bresenham line pixel stepper
// Walks an integer line one pixel per advance item.
// ---------------------------------------------------------------------------
// Usage:
//   req_* channel: one item per transfer. req_action = load takes both
//   endpoints and the colour, starts a new line (dropping any line in
//   progress) and emits the first pixel. req_action = advance emits the next
//   pixel of the active line; with no active line it emits nothing.
//   rsp_* channel: one pixel per transfer, rsp_last set on the endpoint.
//   Path: a pixel passes the input register, then the result register,
//   before it appears on rsp_*.
//   Throughput: one item per cycle unless rsp_stall holds a pixel; set by
//   the single add/compare step of the error term between the two registers.
//   Stall: when rsp_stall holds a waiting pixel, the input register holds
//   one more item and req_stall rises until the pixel is taken.
//   Reset: synchronous; clears both stages and the line state, no line is
//   active afterwards.
// ---------------------------------------------------------------------------
`include "bresenham_line_pixel_stepper_macros.svh"

module bresenham_line_pixel_stepper (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_action,
   input  bls_pkg::coord_type          req_start_x,
   input  bls_pkg::coord_type          req_start_y,
   input  bls_pkg::coord_type          req_end_x,
   input  bls_pkg::coord_type          req_end_y,
   input  bls_pkg::colour_type         req_colour,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bls_pkg::coord_type          rsp_pixel_x,
   output bls_pkg::coord_type          rsp_pixel_y,
   output bls_pkg::colour_type         rsp_pixel_colour,
   output logic                        rsp_last
);

   // input register
   logic                   s1_valid_ff;
   logic                   s1_action_ff;
   bls_pkg::coord_type     s1_start_x_ff;
   bls_pkg::coord_type     s1_start_y_ff;
   bls_pkg::coord_type     s1_end_x_ff;
   bls_pkg::coord_type     s1_end_y_ff;
   bls_pkg::colour_type    s1_colour_ff;

   // line state
   bls_pkg::coord_type     cur_x_ff,       cur_x_in;
   bls_pkg::coord_type     cur_y_ff,       cur_y_in;
   bls_pkg::decision_type  decision_ff,    decision_in;
   bls_pkg::count_type     pixels_left_ff, pixels_left_in;
   bls_pkg::twice_type     twice_dx_ff,    twice_dx_in;
   bls_pkg::twice_type     twice_dy_ff,    twice_dy_in;
   logic                   x_negative_ff,  x_negative_in;
   logic                   y_negative_ff,  y_negative_in;
   logic                   x_major_ff,     x_major_in;
   bls_pkg::colour_type    line_colour_ff, line_colour_in;
   logic                   active_ff,      active_in;

   // result register
   logic                   rsp_valid_ff;
   bls_pkg::coord_type     rsp_pixel_x_ff;
   bls_pkg::coord_type     rsp_pixel_y_ff;
   bls_pkg::colour_type    rsp_pixel_colour_ff;
   logic                   rsp_last_ff;

   // handshake
   logic out_free;
   logic s1_go;
   logic is_load;
   logic emit;

   // load setup
   bls_pkg::diff_type      diff_x;
   bls_pkg::diff_type      diff_y;
   bls_pkg::diff_type      abs_x_full;
   bls_pkg::diff_type      abs_y_full;
   bls_pkg::coord_type     abs_x;
   bls_pkg::coord_type     abs_y;
   logic                   load_x_major;
   bls_pkg::coord_type     load_major;
   bls_pkg::twice_type     load_twice_minor;

   // advance step
   bls_pkg::twice_type     twice_major;
   bls_pkg::twice_type     twice_minor;
   logic                   dec_ge;
   bls_pkg::decision_type  dec_adj;
   logic                   step_x;
   logic                   step_y;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign is_load   = (s1_action_ff == bls_pkg::ACTION_LOAD);
   assign emit      = s1_go && (is_load || active_ff);

   // endpoint distances, signs and major axis (ties go to y)
   assign diff_x     = bls_pkg::diff_type'({1'b0, s1_end_x_ff})
                     - bls_pkg::diff_type'({1'b0, s1_start_x_ff});
   assign diff_y     = bls_pkg::diff_type'({1'b0, s1_end_y_ff})
                     - bls_pkg::diff_type'({1'b0, s1_start_y_ff});
   assign abs_x_full = diff_x[bls_pkg::DIFF_WIDTH-1] ? -diff_x : diff_x;
   assign abs_y_full = diff_y[bls_pkg::DIFF_WIDTH-1] ? -diff_y : diff_y;
   assign abs_x      = abs_x_full[bls_pkg::COORD_WIDTH-1:0];
   assign abs_y      = abs_y_full[bls_pkg::COORD_WIDTH-1:0];
   assign load_x_major     = abs_x > abs_y;
   assign load_major       = load_x_major ? abs_x : abs_y;
   assign load_twice_minor = load_x_major ? {abs_y, 1'b0} : {abs_x, 1'b0};

   // error term step along the current major axis
   assign twice_major = x_major_ff ? twice_dx_ff : twice_dy_ff;
   assign twice_minor = x_major_ff ? twice_dy_ff : twice_dx_ff;
   assign dec_ge      = !decision_ff[bls_pkg::DECISION_WIDTH-1];
   assign dec_adj     = dec_ge ? decision_ff - $signed({2'b00, twice_major}) : decision_ff;
   assign step_x      = x_major_ff || dec_ge;
   assign step_y      = !x_major_ff || dec_ge;

   // next line state
   always_comb begin
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      decision_in    = decision_ff;
      pixels_left_in = pixels_left_ff;
      twice_dx_in    = twice_dx_ff;
      twice_dy_in    = twice_dy_ff;
      x_negative_in  = x_negative_ff;
      y_negative_in  = y_negative_ff;
      x_major_in     = x_major_ff;
      line_colour_in = line_colour_ff;
      active_in      = active_ff;
      if (s1_go && is_load) begin
         cur_x_in       = s1_start_x_ff;
         cur_y_in       = s1_start_y_ff;
         x_negative_in  = diff_x[bls_pkg::DIFF_WIDTH-1];
         y_negative_in  = diff_y[bls_pkg::DIFF_WIDTH-1];
         twice_dx_in    = {abs_x, 1'b0};
         twice_dy_in    = {abs_y, 1'b0};
         x_major_in     = load_x_major;
         decision_in    = $signed({2'b00, load_twice_minor}) - $signed({3'b000, load_major});
         pixels_left_in = {1'b0, load_major};
         line_colour_in = s1_colour_ff;
         active_in      = (load_major != '0);
      end else if (s1_go && active_ff) begin
         if (step_x) begin
            cur_x_in = x_negative_ff ? cur_x_ff - bls_pkg::coord_type'(1)
                                     : cur_x_ff + bls_pkg::coord_type'(1);
         end
         if (step_y) begin
            cur_y_in = y_negative_ff ? cur_y_ff - bls_pkg::coord_type'(1)
                                     : cur_y_ff + bls_pkg::coord_type'(1);
         end
         decision_in    = dec_adj + $signed({2'b00, twice_minor});
         pixels_left_in = pixels_left_ff - bls_pkg::count_type'(1);
         active_in      = (pixels_left_in != '0);
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         s1_action_ff  <= req_action;
         s1_start_x_ff <= req_start_x;
         s1_start_y_ff <= req_start_y;
         s1_end_x_ff   <= req_end_x;
         s1_end_y_ff   <= req_end_y;
         s1_colour_ff  <= req_colour;
      end
   end

   // line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         decision_ff    <= '0;
         pixels_left_ff <= '0;
         twice_dx_ff    <= '0;
         twice_dy_ff    <= '0;
         x_negative_ff  <= 1'b0;
         y_negative_ff  <= 1'b0;
         x_major_ff     <= 1'b0;
         line_colour_ff <= '0;
         active_ff      <= 1'b0;
      end else begin
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         decision_ff    <= decision_in;
         pixels_left_ff <= pixels_left_in;
         twice_dx_ff    <= twice_dx_in;
         twice_dy_ff    <= twice_dy_in;
         x_negative_ff  <= x_negative_in;
         y_negative_ff  <= y_negative_in;
         x_major_ff     <= x_major_in;
         line_colour_ff <= line_colour_in;
         active_ff      <= active_in;
      end
   end

   // result register: the emitted pixel is the updated current pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit;
      end
      if (emit) begin
         rsp_pixel_x_ff      <= cur_x_in;
         rsp_pixel_y_ff      <= cur_y_in;
         rsp_pixel_colour_ff <= line_colour_in;
         rsp_last_ff         <= (pixels_left_in == '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_x      = rsp_pixel_x_ff;
   assign rsp_pixel_y      = rsp_pixel_y_ff;
   assign rsp_pixel_colour = rsp_pixel_colour_ff;
   assign rsp_last         = rsp_last_ff;

   // checks
   `BLS_ASSERT_IMPLIES(a_active_count, clock, reset, 1'b1, active_ff == (pixels_left_ff != '0))
   `BLS_ASSERT_NEXT(a_last_ends_line, clock, reset, emit && (pixels_left_in == '0), !active_ff)
   `BLS_ASSERT_IMPLIES(a_stall_cause, clock, reset, req_stall, s1_valid_ff && rsp_valid_ff && rsp_stall)
   `BLS_ASSERT_NEXT(a_emit_shown, clock, reset, emit, rsp_valid_ff)

endmodule

// File: verif/bresenham_line_pixel_stepper_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Line pixel stepper testbench
// Drives load and advance items into the stepper under several mixes of
// sender gaps and receiver stalls. A local line walker predicts each pixel
// but those of the hand-checked extremes in the short directed table, which
// also covers the corner cases. Random lines follow, most walked to the end,
// some dropped part way, some overrun by advances that must produce nothing.
// ---------------------------------------------------------------------------
module bresenham_line_pixel_stepper_tb;

   localparam int RUN_LIMIT     = 400000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int ITEMS_PER_SET = 250;
   localparam int MAX_WALK      = 40;
   localparam int N_DIRECTED    = 26;

   typedef struct packed {
      bls_pkg::coord_type  x;
      bls_pkg::coord_type  y;
      bls_pkg::colour_type colour;
      logic                last;
   } pixel_type;

   // one stimulus row; has_pixel and pixel only count when hand_checked is set
   typedef struct packed {
      bls_pkg::action_type action;
      bls_pkg::coord_type  sx;
      bls_pkg::coord_type  sy;
      bls_pkg::coord_type  ex;
      bls_pkg::coord_type  ey;
      bls_pkg::colour_type colour;
      logic                hand_checked;
      logic                has_pixel;
      pixel_type           pixel;
   } stim_row_type;

   // directed table: extremes carry their pixel, the rest use the walker
   stim_row_type directed_rows [0:N_DIRECTED-1] = '{
      // advance straight after reset: nothing
      '{bls_pkg::ACTION_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b1, 1'b0, '0},
      // zero-length line at the origin
      '{bls_pkg::ACTION_LOAD, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b1, 1'b1, '{12'h000, 12'h000, 16'h0000, 1'b1}},
      // advance with no line left: nothing
      '{bls_pkg::ACTION_ADVANCE, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 16'hffff,
        1'b1, 1'b0, '0},
      // zero-length line at the far corner
      '{bls_pkg::ACTION_LOAD, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 16'hffff,
        1'b1, 1'b1, '{12'hfff, 12'hfff, 16'hffff, 1'b1}},
      // full-width horizontal
      '{bls_pkg::ACTION_LOAD, 12'h000, 12'h000, 12'hfff, 12'h000, 16'hf800,
        1'b1, 1'b1, '{12'h000, 12'h000, 16'hf800, 1'b0}},
      '{bls_pkg::ACTION_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b0, 1'b0, '0},
      '{bls_pkg::ACTION_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b0, 1'b0, '0},
      // full-height vertical, drops the horizontal line
      '{bls_pkg::ACTION_LOAD, 12'h000, 12'h000, 12'h000, 12'hfff, 16'h07e0,
        1'b1, 1'b1, '{12'h000, 12'h000, 16'h07e0, 1'b0}},
      '{bls_pkg::ACTION_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b0, 1'b0, '0},
      '{bls_pkg::ACTION_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b0, 1'b0, '0},
      // full diagonal toward the origin, dx equal to dy
      '{bls_pkg::ACTION_LOAD, 12'hfff, 12'hfff, 12'h000, 12'h000, 16'h001f,
        1'b1, 1'b1, '{12'hfff, 12'hfff, 16'h001f, 1'b0}},
      '{bls_pkg::ACTION_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b0, 1'b0, '0},
      '{bls_pkg::ACTION_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b0, 1'b0, '0},
      // short x-major line walked to its end and one past
      '{bls_pkg::ACTION_LOAD, 12'd10, 12'd20, 12'd13, 12'd21, 16'haaaa,
        1'b0, 1'b0, '0},
      '{bls_pkg::ACTION_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b0, 1'b0, '0},
      '{bls_pkg::ACTION_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b0, 1'b0, '0},
      '{bls_pkg::ACTION_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b0, 1'b0, '0},
      '{bls_pkg::ACTION_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b0, 1'b0, '0},
      // y-major line stepping x down, then dropped
      '{bls_pkg::ACTION_LOAD, 12'd5, 12'd5, 12'd3, 12'd9, 16'h5555,
        1'b0, 1'b0, '0},
      '{bls_pkg::ACTION_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b0, 1'b0, '0},
      '{bls_pkg::ACTION_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b0, 1'b0, '0},
      // x-major line stepping both axes down
      '{bls_pkg::ACTION_LOAD, 12'd100, 12'd200, 12'd90, 12'd195, 16'h1234,
        1'b0, 1'b0, '0},
      '{bls_pkg::ACTION_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b0, 1'b0, '0},
      '{bls_pkg::ACTION_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b0, 1'b0, '0},
      // one-step vertical line
      '{bls_pkg::ACTION_LOAD, 12'd7, 12'd7, 12'd7, 12'd8, 16'hc3c3,
        1'b0, 1'b0, '0},
      '{bls_pkg::ACTION_ADVANCE, 12'h000, 12'h000, 12'h000, 12'h000, 16'h0000,
        1'b0, 1'b0, '0}
   };

   // sender gap and receiver stall mix per random set
   int phase_idle_pct  [4] = '{0, 79, 0, 29};
   int phase_stall_pct [4] = '{0, 0, 79, 29};

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   bls_pkg::action_type   req_action       = bls_pkg::ACTION_LOAD;
   bls_pkg::coord_type    req_start_x      = '0;
   bls_pkg::coord_type    req_start_y      = '0;
   bls_pkg::coord_type    req_end_x        = '0;
   bls_pkg::coord_type    req_end_y        = '0;
   bls_pkg::colour_type   req_colour       = '0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   bls_pkg::coord_type    rsp_pixel_x;
   bls_pkg::coord_type    rsp_pixel_y;
   bls_pkg::colour_type   rsp_pixel_colour;
   logic                  rsp_last;

   // row info travelling with the payload on the request ports
   stim_row_type          req_row          = '0;
   int                    sender_idle_pct  = 0;
   int                    stall_pct        = 0;
   int                    cycle_count      = 0;
   int                    mismatch_count   = 0;

   pixel_type             expected_pixels [$];

   // line walker state
   bls_pkg::coord_type    walk_x;
   bls_pkg::coord_type    walk_y;
   bls_pkg::decision_type walk_error;
   bls_pkg::count_type    walk_left;
   bls_pkg::twice_type    walk_twice_dx;
   bls_pkg::twice_type    walk_twice_dy;
   logic                  walk_x_down;
   logic                  walk_y_down;
   logic                  walk_x_major;
   bls_pkg::colour_type   walk_colour;
   logic                  walk_active;

   bresenham_line_pixel_stepper u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_colour       (req_colour),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_colour (rsp_pixel_colour),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // clear the walker, as after reset
   function automatic void walker_reset();
      walk_x        = '0;
      walk_y        = '0;
      walk_error    = '0;
      walk_left     = '0;
      walk_twice_dx = '0;
      walk_twice_dy = '0;
      walk_x_down   = 1'b0;
      walk_y_down   = 1'b0;
      walk_x_major  = 1'b0;
      walk_colour   = '0;
      walk_active   = 1'b0;
   endfunction

   // apply one item to the walker; returns 1 when a pixel comes out
   function automatic logic walk_line(input stim_row_type row, output pixel_type pix);
      int dx;
      int dy;
      pix = '0;
      if (row.action == bls_pkg::ACTION_LOAD) begin
         dx = int'(row.ex) - int'(row.sx);
         dy = int'(row.ey) - int'(row.sy);
         walk_x_down = (dx < 0);
         if (dx < 0) dx = -dx;
         walk_y_down = (dy < 0);
         if (dy < 0) dy = -dy;
         walk_twice_dx = bls_pkg::twice_type'(2 * dx);
         walk_twice_dy = bls_pkg::twice_type'(2 * dy);
         // a tie walks along y
         walk_x_major = (dx > dy);
         if (walk_x_major) begin
            walk_error = bls_pkg::decision_type'(2 * dy - dx);
            walk_left  = bls_pkg::count_type'(dx);
         end else begin
            walk_error = bls_pkg::decision_type'(2 * dx - dy);
            walk_left  = bls_pkg::count_type'(dy);
         end
         walk_x      = row.sx;
         walk_y      = row.sy;
         walk_colour = row.colour;
         walk_active = (walk_left != 0);
      end else begin
         if (!walk_active) return 1'b0;
         if (walk_x_major) begin
            if (walk_error >= 0) begin
               walk_error = walk_error - bls_pkg::decision_type'(walk_twice_dx);
               walk_y     = walk_y_down ? walk_y - 1'b1 : walk_y + 1'b1;
            end
            walk_error = walk_error + bls_pkg::decision_type'(walk_twice_dy);
            walk_x     = walk_x_down ? walk_x - 1'b1 : walk_x + 1'b1;
         end else begin
            if (walk_error >= 0) begin
               walk_error = walk_error - bls_pkg::decision_type'(walk_twice_dy);
               walk_x     = walk_x_down ? walk_x - 1'b1 : walk_x + 1'b1;
            end
            walk_error = walk_error + bls_pkg::decision_type'(walk_twice_dx);
            walk_y     = walk_y_down ? walk_y - 1'b1 : walk_y + 1'b1;
         end
         walk_left = walk_left - 1'b1;
         if (walk_left == 0) walk_active = 1'b0;
      end
      pix = '{walk_x, walk_y, walk_colour, (walk_left == 0)};
      return 1'b1;
   endfunction

   function automatic bls_pkg::coord_type clamp_coord(input int value);
      if (value < 0) return '0;
      if (value > 4095) return '1;
      return bls_pkg::coord_type'(value);
   endfunction

   // present one item, with random sender gaps, and wait for its transfer
   task automatic send_item(input stim_row_type row);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= row.action;
      req_start_x <= row.sx;
      req_start_y <= row.sy;
      req_end_x   <= row.ex;
      req_end_y   <= row.ey;
      req_colour  <= row.colour;
      req_row     <= row;
      do @(posedge clock); while (req_stall);
   endtask

   // one random line: load, then a walk that may finish, stop early or overrun
   task automatic draw_line(output int counted);
      stim_row_type       row;
      bls_pkg::coord_type sx;
      bls_pkg::coord_type sy;
      bls_pkg::coord_type ex;
      bls_pkg::coord_type ey;
      int                 shape;
      int                 off_x;
      int                 off_y;
      int                 span_x;
      int                 span_y;
      int                 span;
      int                 mode;
      int                 n_adv;
      sx    = bls_pkg::coord_type'($urandom);
      sy    = bls_pkg::coord_type'($urandom);
      shape = $urandom_range(99);
      off_x = int'($urandom_range(40)) - 20;
      off_y = int'($urandom_range(40)) - 20;
      if (shape < 8) begin
         ex = bls_pkg::coord_type'($urandom);
         ey = bls_pkg::coord_type'($urandom);
      end else begin
         if (shape < 18) off_y = 0;
         else if (shape < 28) off_x = 0;
         else if (shape < 40) off_y = $urandom_range(1) ? off_x : -off_x;
         else if (shape < 44) begin
            off_x = 0;
            off_y = 0;
         end
         ex = clamp_coord(int'(sx) + off_x);
         ey = clamp_coord(int'(sy) + off_y);
      end
      span_x = int'(ex) - int'(sx);
      span_y = int'(ey) - int'(sy);
      if (span_x < 0) span_x = -span_x;
      if (span_y < 0) span_y = -span_y;
      span = (span_x > span_y) ? span_x : span_y;
      mode = $urandom_range(99);
      if (mode < 70) n_adv = span;
      else if (mode < 85) n_adv = $urandom_range(span);
      else n_adv = span + $urandom_range(3, 1);
      // long lines are dropped part way
      if (n_adv > MAX_WALK) n_adv = $urandom_range(MAX_WALK);
      row = '{bls_pkg::ACTION_LOAD, sx, sy, ex, ey, bls_pkg::colour_type'($urandom),
              1'b0, 1'b0, '0};
      send_item(row);
      repeat (n_adv) begin
         row = '{bls_pkg::ACTION_ADVANCE,
                 bls_pkg::coord_type'($urandom), bls_pkg::coord_type'($urandom),
                 bls_pkg::coord_type'($urandom), bls_pkg::coord_type'($urandom),
                 bls_pkg::colour_type'($urandom), 1'b0, 1'b0, '0};
         send_item(row);
      end
      counted = 1 + ((n_adv < span) ? n_adv : span);
   endtask

   // receiver stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // predict on request transfers, check on response transfers
   always @(posedge clock) begin : pixel_monitor
      pixel_type want;
      pixel_type got;
      logic      has_pixel;
      if (reset) begin
         walker_reset();
      end else begin
         if (req_valid && !req_stall) begin
            has_pixel = walk_line(req_row, want);
            if (req_row.hand_checked) begin
               has_pixel = req_row.has_pixel;
               want      = req_row.pixel;
            end
            if (has_pixel) expected_pixels.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_pixel_x, rsp_pixel_y, rsp_pixel_colour, rsp_last};
            if (expected_pixels.size() == 0) begin
               $error("pixel transfer with none expected: x %0d y %0d", got.x, got.y);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (got.x !== want.x) begin
                  $error("pixel_x: expected %0d, got %0d", want.x, got.x);
                  mismatch_count++;
               end
               if (got.y !== want.y) begin
                  $error("pixel_y: expected %0d, got %0d", want.y, got.y);
                  mismatch_count++;
               end
               if (got.colour !== want.colour) begin
                  $error("pixel_colour: expected %h, got %h", want.colour, got.colour);
                  mismatch_count++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, got.last);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      int counted;
      int set_count;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_item(directed_rows[i]);
      end

      // random lines under each gap and stall mix
      for (int phase = 0; phase < 4; phase++) begin
         // hold off until every pixel so far has come out; the idle edge lets
         // the monitor queue the last transfer first
         req_valid <= 1'b0;
         @(posedge clock);
         while (expected_pixels.size() != 0) @(posedge clock);
         sender_idle_pct = phase_idle_pct[phase];
         stall_pct      <= phase_stall_pct[phase];
         set_count = 0;
         while (set_count < ITEMS_PER_SET) begin
            draw_line(counted);
            set_count += counted;
         end
      end

      // drain
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/bls_pkg.sv
design/bresenham_line_pixel_stepper.sv
verif/bresenham_line_pixel_stepper_tb.sv
